/* src/wlr_pkg.sv */
// Shared types, constants and color conversion for the wide line rasterizer.
`default_nettype none

package wlr_pkg;

  // Fixed field widths of the input and output words
  localparam int unsigned CoordInW = 12;
  localparam int unsigned PixW     = 16;
  localparam int unsigned WidthW   = 5;
  localparam int unsigned ArgbW    = 32;

  // Maximum stroke width the width field can carry
  localparam int unsigned WidthFieldMax = 31;

  // Transparency: any bit set in the alpha byte suppresses the line
  localparam int unsigned AlphaLsb = 24;
  localparam logic [7:0]  AlphaClear = 8'h00;

  // Field positions in RGB565
  localparam int unsigned RedLsb565   = 11;
  localparam int unsigned GreenLsb565 = 5;

  // Command codes
  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep  = 1'b1;

  // One queued run: all pixels of one major-axis position
  typedef struct packed {
    logic [PixW-1:0]   major;
    logic [PixW-1:0]   minor_base;
    logic [PixW-1:0]   color;
    logic [WidthW-1:0] width;
    logic              steep;
    logic              last;
  } run_t;

  // RGB888 (low 24 bits) to RGB565
  function automatic logic [PixW-1:0] to_rgb565(input logic [ArgbW-1:0] argb);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = argb[23:19];
    g6 = argb[15:10];
    b5 = argb[7:3];
    return (PixW'(r5) << RedLsb565) | (PixW'(g6) << GreenLsb565) | PixW'(b5);
  endfunction

endpackage

`default_nettype wire

/* src/wlr_if.sv */
// Handshake interfaces for the command and pixel channels.
`default_nettype none

interface wlr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] start_x;
  logic [11:0] start_y;
  logic [11:0] end_x;
  logic [11:0] end_y;
  logic [31:0] argb_color;
  logic [4:0]  stroke_width;

  modport source (
    output valid, command, start_x, start_y, end_x, end_y, argb_color, stroke_width,
    input  ready
  );
  modport sink (
    input  valid, command, start_x, start_y, end_x, end_y, argb_color, stroke_width,
    output ready
  );
endinterface

interface wlr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [15:0] pixel_rgb565;
  logic        run_last;
  logic        line_done;

  modport source (
    output valid, pixel_x, pixel_y, pixel_rgb565, run_last, line_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_rgb565, run_last, line_done,
    output ready
  );
endinterface

`default_nettype wire

/* src/wide_line_rasterizer.sv */
// Top level of the wide line rasterizer.
// A start word sets up a line and returns nothing; each step word then yields one
// run of stroke_width pixels across the minor axis for the next major position,
// and the last pixel of the final run carries line_done. The back end sends one
// pixel per cycle while the output is ready; a run holds 1 to min(MAX_WIDTH, 31)
// pixels, 16 by default. The front end takes one word per cycle while the queue
// has room and runs ahead by up to two queued runs. Steps with no line in progress
// are dropped, and transparent, zero-width or single-point lines draw nothing.
`default_nettype none

module wide_line_rasterizer #(
  parameter int unsigned MAX_WIDTH  = 16,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  wlr_in_if.sink     in_i,
  wlr_out_if.source  out_o
);

  wlr_pkg::run_t push_data, head;
  logic          push, full, pop, avail;

  wlr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (full),
    .q_push_o (push),
    .q_data_o (push_data)
  );

  wlr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .avail_o     (avail),
    .head_o      (head)
  );

  wlr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

/* src/wlr_front.sv */
// Front end: takes command words, sets up lines and issues one run per step.
`default_nettype none

module wlr_front #(
  parameter int unsigned MAX_WIDTH  = 16,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  wlr_in_if.sink         in_i,
  input  wire            q_full_i,
  output logic           q_push_o,
  output wlr_pkg::run_t  q_data_o
);

  localparam int unsigned CoordW = (COORD_BITS < wlr_pkg::CoordInW) ?
                                   COORD_BITS : wlr_pkg::CoordInW;
  localparam int unsigned SumW   = CoordW + 2;
  localparam int unsigned MaxRun = (MAX_WIDTH < wlr_pkg::WidthFieldMax) ?
                                   MAX_WIDTH : wlr_pkg::WidthFieldMax;

  // Line state
  logic                     busy_q,        busy_d;
  logic                     steep_q,       steep_d;
  logic                     dir_q,         dir_d;
  logic [CoordW:0]          index_q,       index_d;
  logic [CoordW-1:0]        len_q,         len_d;
  logic [CoordW-1:0]        start_maj_q,   start_maj_d;
  logic [CoordW-1:0]        start_min_q,   start_min_d;
  logic signed [CoordW:0]   delta_q,       delta_d;
  logic signed [CoordW:0]   quot_q,        quot_d;
  logic [CoordW-1:0]        rem_q,         rem_d;
  logic [wlr_pkg::WidthW-1:0] width_q,     width_d;
  logic [wlr_pkg::PixW-1:0] color_q,       color_d;

  // Setup arithmetic
  logic [CoordW-1:0]      sx, sy, ex, ey;
  logic signed [CoordW:0] dx, dy, ndx, ndy;
  logic [CoordW-1:0]      adx, ady;
  logic                   no_draw;
  logic                   accept;
  logic                   last_step;
  logic signed [SumW-1:0] rem_sum, len_ext;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  assign sx  = in_i.start_x[CoordW-1:0];
  assign sy  = in_i.start_y[CoordW-1:0];
  assign ex  = in_i.end_x[CoordW-1:0];
  assign ey  = in_i.end_y[CoordW-1:0];
  assign dx  = $signed({1'b0, ex}) - $signed({1'b0, sx});
  assign dy  = $signed({1'b0, ey}) - $signed({1'b0, sy});
  assign ndx = -dx;
  assign ndy = -dy;
  assign adx = dx[CoordW] ? ndx[CoordW-1:0] : dx[CoordW-1:0];
  assign ady = dy[CoordW] ? ndy[CoordW-1:0] : dy[CoordW-1:0];

  assign no_draw = (in_i.argb_color[wlr_pkg::AlphaLsb +: 8] != wlr_pkg::AlphaClear) ||
                   (in_i.stroke_width == '0) || ((dx == '0) && (dy == '0));

  // Run for the current major position
  assign last_step = (index_q >= {1'b0, len_q});
  assign q_push_o  = accept && (in_i.command == wlr_pkg::CmdStep) && busy_q;

  always_comb begin
    q_data_o.major = dir_q ?
        wlr_pkg::PixW'(start_maj_q) - wlr_pkg::PixW'(index_q) :
        wlr_pkg::PixW'(start_maj_q) + wlr_pkg::PixW'(index_q);
    q_data_o.minor_base = wlr_pkg::PixW'(start_min_q) + wlr_pkg::PixW'(quot_q);
    q_data_o.color      = color_q;
    q_data_o.width      = width_q;
    q_data_o.steep      = steep_q;
    q_data_o.last       = last_step;
  end

  // Incremental floor(i * dminor / len): remainder stays in [0, len)
  assign rem_sum = $signed({2'b00, rem_q}) + SumW'(delta_q);
  assign len_ext = $signed({2'b00, len_q});

  // Next line state
  always_comb begin
    busy_d      = busy_q;
    steep_d     = steep_q;
    dir_d       = dir_q;
    index_d     = index_q;
    len_d       = len_q;
    start_maj_d = start_maj_q;
    start_min_d = start_min_q;
    delta_d     = delta_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    width_d     = width_q;
    color_d     = color_q;
    if (accept && (in_i.command == wlr_pkg::CmdStart)) begin
      busy_d = !no_draw;
      if (!no_draw) begin
        if (adx > ady) begin
          steep_d     = 1'b0;
          len_d       = adx;
          dir_d       = dx[CoordW];
          start_maj_d = sx;
          start_min_d = sy;
          delta_d     = dy;
        end else begin
          steep_d     = 1'b1;
          len_d       = ady;
          dir_d       = dy[CoordW];
          start_maj_d = sy;
          start_min_d = sx;
          delta_d     = dx;
        end
        width_d = (in_i.stroke_width > wlr_pkg::WidthW'(MaxRun)) ?
                  wlr_pkg::WidthW'(MaxRun) : in_i.stroke_width;
        color_d = wlr_pkg::to_rgb565(in_i.argb_color);
        index_d = '0;
        quot_d  = '0;
        rem_d   = '0;
      end
    end else if (q_push_o) begin
      if (rem_sum >= len_ext) begin
        rem_d  = CoordW'(rem_sum - len_ext);
        quot_d = quot_q + 1'b1;
      end else if (rem_sum < 0) begin
        rem_d  = CoordW'(rem_sum + len_ext);
        quot_d = quot_q - 1'b1;
      end else begin
        rem_d  = CoordW'(rem_sum);
      end
      index_d = index_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      steep_q     <= 1'b0;
      dir_q       <= 1'b0;
      index_q     <= '0;
      len_q       <= '0;
      start_maj_q <= '0;
      start_min_q <= '0;
      delta_q     <= '0;
      quot_q      <= '0;
      rem_q       <= '0;
      width_q     <= '0;
      color_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      steep_q     <= steep_d;
      dir_q       <= dir_d;
      index_q     <= index_d;
      len_q       <= len_d;
      start_maj_q <= start_maj_d;
      start_min_q <= start_min_d;
      delta_q     <= delta_d;
      quot_q      <= quot_d;
      rem_q       <= rem_d;
      width_q     <= width_d;
      color_q     <= color_d;
    end
  end

endmodule

`default_nettype wire

/* src/wlr_queue.sv */
// Two-entry run queue between the front and back ends.
`default_nettype none

module wlr_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  wlr_pkg::run_t  push_data_i,
  output logic           full_o,
  input  wire            pop_i,
  output logic           avail_o,
  output wlr_pkg::run_t  head_o
);

  wlr_pkg::run_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'd2);
  assign avail_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/wlr_back.sv */
// Back end: expands each queued run into pixels, one per cycle while the output is ready.
`default_nettype none

module wlr_back (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            avail_i,
  input  wlr_pkg::run_t  head_i,
  output logic           pop_o,
  wlr_out_if.source      out_o
);

  logic [wlr_pkg::WidthW-1:0] pos_q;
  logic                       valid_q;
  logic [wlr_pkg::PixW-1:0]   x_q, y_q, color_q;
  logic                       run_last_q, line_done_q;
  logic                       load, final_pix;
  logic [wlr_pkg::PixW-1:0]   minor;

  assign load      = avail_i && (!valid_q || out_o.ready);
  assign final_pix = ((pos_q + 1'b1) == head_i.width);
  assign pop_o     = load && final_pix;
  assign minor     = head_i.minor_base + wlr_pkg::PixW'(pos_q);

  // Pixel position within the run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        pos_q   <= final_pix ? '0 : pos_q + 1'b1;
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q         <= head_i.steep ? minor : head_i.major;
      y_q         <= head_i.steep ? head_i.major : minor;
      color_q     <= head_i.color;
      run_last_q  <= final_pix;
      line_done_q <= final_pix && head_i.last;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.pixel_x      = x_q;
  assign out_o.pixel_y      = y_q;
  assign out_o.pixel_rgb565 = color_q;
  assign out_o.run_last     = run_last_q;
  assign out_o.line_done    = line_done_q;

endmodule

`default_nettype wire
